// File: rtl/ovl_pkg.sv
// ----------------------------------------------------------------------------
// ovl_pkg
// Shared types and codes for the ordered value list: request and response
// payloads, request and status codes, and the controller/datapath interface.
// ----------------------------------------------------------------------------
package ovl_pkg;

  // default number of entries
  localparam int unsigned CapacityDef = 16;

  // field widths
  localparam int unsigned ValueW = 32;
  localparam int unsigned ReqW   = 3;
  localparam int unsigned StatW  = 2;
  localparam int unsigned PosW   = 4;
  localparam int unsigned CountW = 5;

  // request codes
  localparam logic [ReqW-1:0] REQ_INS_FRONT = 3'd0;
  localparam logic [ReqW-1:0] REQ_INS_BACK  = 3'd1;
  localparam logic [ReqW-1:0] REQ_REM_FRONT = 3'd2;
  localparam logic [ReqW-1:0] REQ_REM_BACK  = 3'd3;
  localparam logic [ReqW-1:0] REQ_REM_VALUE = 3'd4;
  localparam logic [ReqW-1:0] REQ_SEARCH    = 3'd5;

  // status codes
  localparam logic [StatW-1:0] ST_OK        = 2'd0;
  localparam logic [StatW-1:0] ST_EMPTY     = 2'd1;
  localparam logic [StatW-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [StatW-1:0] ST_FULL      = 2'd3;

  // request payload
  typedef struct packed {
    logic [ReqW-1:0]          req_type;
    logic signed [ValueW-1:0] item_value;
  } req_t;

  // response payload
  typedef struct packed {
    logic [StatW-1:0]  status;
    logic [PosW-1:0]   position;
    logic [CountW-1:0] entry_count;
  } rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic             load_req;
    logic             start_scan;
    logic             start_shift;
    logic             scan;
    logic             shift;
    logic             write_front;
    logic             write_back;
    logic             dec_count;
    logic             set_st;
    logic [StatW-1:0] st;
    logic             load_rsp;
  } ovl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [ReqW-1:0] req_type;
    logic            empty;
    logic            full;
    logic            single;
    logic            rd_more;
    logic            dv;
    logic            found;
  } ovl_stat_t;

endpackage

// File: rtl/ovl_ram.sv
// ----------------------------------------------------------------------------
// ovl_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module ovl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: rtl/ovl_ctrl.sv
// ----------------------------------------------------------------------------
// ovl_ctrl
// Request sequencer: decodes each request, steps the datapath through its
// scan or shift walk and hands the response to the output register.
// ----------------------------------------------------------------------------
module ovl_ctrl
  import ovl_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  ovl_stat_t stat_i,
  output ovl_cmd_t  cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_SCAN   = 6'b000100,
    S_SHIFT  = 6'b001000,
    S_WFRONT = 6'b010000,
    S_DONE   = 6'b100000
  } state_e;

  state_e   state_q, state_d;
  logic     out_valid_q, out_valid_d;
  ovl_cmd_t cmd;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd     = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.load_req = 1'b1;
          state_d      = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_DONE;
        unique case (stat_i.req_type)
          REQ_INS_FRONT: begin
            priority if (stat_i.full) begin
              cmd.set_st = 1'b1;
              cmd.st     = ST_FULL;
            end else if (stat_i.empty) begin
              state_d = S_WFRONT;
            end else begin
              cmd.start_shift = 1'b1;
              state_d         = S_SHIFT;
            end
          end
          REQ_INS_BACK: begin
            if (stat_i.full) begin
              cmd.set_st = 1'b1;
              cmd.st     = ST_FULL;
            end else begin
              cmd.write_back = 1'b1;
            end
          end
          REQ_REM_FRONT: begin
            priority if (stat_i.empty) begin
              cmd.set_st = 1'b1;
              cmd.st     = ST_EMPTY;
            end else if (stat_i.single) begin
              cmd.dec_count = 1'b1;
            end else begin
              cmd.start_scan = 1'b1;
              state_d        = S_SCAN;
            end
          end
          REQ_REM_BACK: begin
            if (stat_i.empty) begin
              cmd.set_st = 1'b1;
              cmd.st     = ST_EMPTY;
            end else begin
              cmd.dec_count = 1'b1;
            end
          end
          REQ_REM_VALUE: begin
            if (stat_i.empty) begin
              cmd.set_st = 1'b1;
              cmd.st     = ST_EMPTY;
            end else begin
              cmd.start_scan = 1'b1;
              state_d        = S_SCAN;
            end
          end
          REQ_SEARCH: begin
            if (stat_i.empty) begin
              cmd.set_st = 1'b1;
              cmd.st     = ST_NOT_FOUND;
            end else begin
              cmd.start_scan = 1'b1;
              state_d        = S_SCAN;
            end
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        // last read data is being handled this cycle
        if (stat_i.dv && !stat_i.rd_more) begin
          state_d = S_DONE;
          if (stat_i.found) begin
            cmd.dec_count = (stat_i.req_type != REQ_SEARCH);
          end else begin
            cmd.set_st = 1'b1;
            cmd.st     = ST_NOT_FOUND;
          end
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (stat_i.dv && !stat_i.rd_more) begin
          state_d = S_WFRONT;
        end
      end
      S_WFRONT: begin
        cmd.write_front = 1'b1;
        state_d         = S_DONE;
      end
      S_DONE: begin
        // hand over once the output register is free
        if (!out_valid_q || !out_stall_i) begin
          cmd.load_rsp = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output register valid
  assign out_valid_d = (out_valid_q && out_stall_i) || cmd.load_rsp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

// File: rtl/ovl_dp.sv
// ----------------------------------------------------------------------------
// ovl_dp
// List datapath: entry store, entry count, walk pointer, match logic and
// the response register.
// ----------------------------------------------------------------------------
module ovl_dp
  import ovl_pkg::*;
#(
  parameter int unsigned CAPACITY = CapacityDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  req_t      in_data_i,
  input  ovl_cmd_t  cmd_i,
  output ovl_stat_t stat_o,
  output rsp_t      out_data_o
);

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  req_t             req_q;
  logic [StatW-1:0] st_q;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  count_m1;
  logic [IdxW-1:0]  ptr_q, ptr_d;
  logic             rd_more_q, rd_more_d;
  logic             dv_q;
  logic [IdxW-1:0]  dptr_q;
  logic             found_q, found_d;
  logic [IdxW-1:0]  pos_q, pos_d;
  rsp_t             rsp_q;

  logic              re;
  logic              we;
  logic [IdxW-1:0]   waddr;
  logic [ValueW-1:0] wdata;
  logic [ValueW-1:0] rdata;
  logic              match;
  logic              is_search;

  assign count_m1  = count_q - CntW'(1);
  assign is_search = (req_q.req_type == REQ_SEARCH);
  assign match     = dv_q && (rdata == req_q.item_value);

  // walk pointer, read issue and match tracking
  always_comb begin
    ptr_d     = ptr_q;
    rd_more_d = rd_more_q;
    found_d   = found_q;
    pos_d     = pos_q;
    priority if (cmd_i.start_scan) begin
      // removal of the front entry starts past it, already matched
      ptr_d     = (req_q.req_type == REQ_REM_FRONT) ? IdxW'(1) : '0;
      found_d   = (req_q.req_type == REQ_REM_FRONT);
      pos_d     = '0;
      rd_more_d = 1'b1;
    end else if (cmd_i.start_shift) begin
      ptr_d     = count_m1[IdxW-1:0];
      rd_more_d = 1'b1;
    end else if (cmd_i.scan) begin
      if (rd_more_q) begin
        if (ptr_q == count_m1[IdxW-1:0]) begin
          rd_more_d = 1'b0;
        end else begin
          ptr_d = ptr_q + IdxW'(1);
        end
      end
      if (match && !found_q) begin
        found_d = 1'b1;
        pos_d   = dptr_q;
      end
    end else if (cmd_i.shift) begin
      if (rd_more_q) begin
        if (ptr_q == '0) begin
          rd_more_d = 1'b0;
        end else begin
          ptr_d = ptr_q - IdxW'(1);
        end
      end
    end
  end

  assign re = (cmd_i.scan || cmd_i.shift) && rd_more_q;

  // store write port
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = rdata;
    priority if (cmd_i.write_back) begin
      we    = 1'b1;
      waddr = count_q[IdxW-1:0];
      wdata = req_q.item_value;
    end else if (cmd_i.write_front) begin
      we    = 1'b1;
      waddr = '0;
      wdata = req_q.item_value;
    end else if (cmd_i.shift && dv_q) begin
      // move one entry toward the back
      we    = 1'b1;
      waddr = dptr_q + IdxW'(1);
    end else if (cmd_i.scan && dv_q && found_q && !is_search) begin
      // close the gap left by the removed entry
      we    = 1'b1;
      waddr = dptr_q - IdxW'(1);
    end
  end

  // entry count
  always_comb begin
    count_d = count_q;
    priority if (cmd_i.write_back || cmd_i.write_front) begin
      count_d = count_q + CntW'(1);
    end else if (cmd_i.dec_count) begin
      count_d = count_m1;
    end
  end

  ovl_ram #(
    .WIDTH(ValueW),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(ptr_q),
    .rdata_o(rdata)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      rd_more_q <= 1'b0;
      dv_q      <= 1'b0;
      found_q   <= 1'b0;
    end else begin
      count_q   <= count_d;
      rd_more_q <= rd_more_d;
      dv_q      <= re;
      found_q   <= found_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    ptr_q  <= ptr_d;
    pos_q  <= pos_d;
    dptr_q <= ptr_q;
    if (cmd_i.load_req) begin
      req_q <= in_data_i;
    end
    if (cmd_i.load_req) begin
      st_q <= ST_OK;
    end else if (cmd_i.set_st) begin
      st_q <= cmd_i.st;
    end
    if (cmd_i.load_rsp) begin
      rsp_q.status      <= st_q;
      rsp_q.position    <= (is_search && st_q == ST_OK) ? PosW'(pos_q) : '0;
      rsp_q.entry_count <= CountW'(count_q);
    end
  end

  // status toward the controller
  always_comb begin
    stat_o.req_type = req_q.req_type;
    stat_o.empty    = (count_q == '0);
    stat_o.full     = (count_q == CntW'(CAPACITY));
    stat_o.single   = (count_q == CntW'(1));
    stat_o.rd_more  = rd_more_q;
    stat_o.dv       = dv_q;
    stat_o.found    = found_q || match;
  end

  assign out_data_o = rsp_q;

endmodule

// File: rtl/ordered_value_list.sv
// Flow per request: accept and decode, then straight to the response for insert back,
// remove back, single-entry remove front, refused and spare requests; search and
// remove value first walk the store from the front, remove front walks it from the
// second entry, and insert front shifts entries back, then writes the front; one store
// read per cycle in a walk. One request in work at a time; the next is taken as the response is offered.
// Reset clears the entry count and control; the store itself is not cleared.
// ----------------------------------------------------------------------------
// ordered_value_list
// Bounded ordered list of signed 32-bit values with front/back insert and
// remove, remove by value and search, built as sequencer plus datapath.
// ----------------------------------------------------------------------------
module ordered_value_list
  import ovl_pkg::*;
#(
  parameter int unsigned CAPACITY = CapacityDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_data_o
);

  ovl_cmd_t  cmd;
  ovl_stat_t stat;

  // request sequencer
  ovl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // list storage and response
  ovl_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_data_i (in_data_i),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .out_data_o(out_data_o)
  );

endmodule
